// ===== hdl/lcgrr_pkg.sv =====
// shared constants and types for the lcg random range generator
`timescale 1ns / 1ps

package lcgrr_pkg;

  localparam int unsigned LANES     = 4;
  localparam int unsigned LANE_IDX_W = 2;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DRAW_W    = 15;
  localparam int unsigned PROD_W    = DRAW_W + DATA_W;
  localparam int unsigned REM_W     = DATA_W + 1;
  localparam int unsigned ITER_W    = 6;
  localparam int unsigned ADDR_W    = 3;

  localparam logic [DATA_W-1:0] LCG_MUL  = 32'd214013;
  localparam logic [DATA_W-1:0] LCG_ADD  = 32'd2531011;
  localparam logic [DRAW_W-1:0] DRAW_MAX = 15'h7FFF;
  localparam int unsigned       DRAW_LSB = 16;

  // fractional divide steps, counted down
  localparam logic [ITER_W-1:0] FRAC_STEP_EST = ITER_W'(3);
  localparam logic [ITER_W-1:0] FRAC_STEP_REM = ITER_W'(2);
  localparam logic [ITER_W-1:0] FRAC_STEP_FIX = ITER_W'(1);

  localparam logic [ITER_W-1:0] INT_ITERS  = ITER_W'(DRAW_W);
  localparam logic [ITER_W-1:0] FRAC_ITERS = FRAC_STEP_EST;

  // multiples of 32767 for the fractional quotient fix-up
  localparam logic [PROD_W-1:0] FRAC_M1 = PROD_W'(DRAW_MAX);
  localparam logic [PROD_W-1:0] FRAC_M2 = FRAC_M1 + FRAC_M1;
  localparam logic [PROD_W-1:0] FRAC_M3 = FRAC_M2 + FRAC_M1;

  // register index decoded from paddr[2]
  localparam logic REG_SEED = 1'b0;

  localparam logic MODE_INT  = 1'b0;
  localparam logic MODE_FRAC = 1'b1;

  typedef struct packed {
    logic              load;
    logic              start;
    logic              mode;
    logic [DRAW_W-1:0] draw;
  } lane_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] value;
  } lane_stat_t;

endpackage

// ===== hdl/lcgrr_lcg.sv =====
// generator state, seed register and configuration port
`timescale 1ns / 1ps

module lcgrr_lcg import lcgrr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  input  logic              step_i,
  output logic [DRAW_W-1:0] draw_o
);

  logic [DATA_W-1:0] seed_q;
  logic [DATA_W-1:0] state_q, state_d;
  logic [DATA_W-1:0] next_state;
  logic              seed_wr;

  assign seed_wr    = psel && penable && pwrite && (paddr[2] == REG_SEED);
  assign next_state = state_q * LCG_MUL + LCG_ADD;
  assign draw_o     = next_state[DRAW_LSB +: DRAW_W];
  assign prdata     = (paddr[2] == REG_SEED) ? seed_q : '0;

  always_comb begin
    state_d = state_q;
    if (seed_wr) begin
      state_d = pwdata;
    end else if (step_i) begin
      state_d = next_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      state_q <= '0;
    end else begin
      state_q <= state_d;
      if (seed_wr) begin
        seed_q <= pwdata;
      end
    end
  end

endmodule

// ===== hdl/lcgrr_lane.sv =====
// one lane: bound ordering, draw scaling and a restoring divider
`timescale 1ns / 1ps

module lcgrr_lane import lcgrr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lane_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] bound_a_i,
  input  logic signed [DATA_W-1:0] bound_b_i,
  output lane_stat_t               stat_o
);

  typedef enum logic [3:0] {
    LN_IDLE = 4'b0001,
    LN_MUL  = 4'b0010,
    LN_DIV  = 4'b0100,
    LN_DONE = 4'b1000
  } lane_state_e;

  lane_state_e       st_q, st_d;
  logic              mode_q;
  logic [DRAW_W-1:0] draw_q;
  logic [DATA_W-1:0] lo_q;
  logic [DATA_W-1:0] span_q;
  logic [REM_W-1:0]  div_q;
  logic [REM_W-1:0]  rem_q;
  logic [PROD_W-1:0] dq_q;
  logic [ITER_W-1:0] iter_q;

  logic              a_lt_b;
  logic [PROD_W-1:0] prod;
  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              fits;
  logic [DATA_W-1:0] offset;
  logic [REM_W-1:0]  q_est;
  logic [PROD_W-1:0] frac_rem;
  logic [1:0]        frac_fix;

  assign a_lt_b = bound_a_i < bound_b_i;
  assign prod   = PROD_W'(draw_q) * PROD_W'(span_q);

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, dq_q[PROD_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  // divide by 2^15 - 1: the sum of 15-bit shifts falls short of the quotient by at most three
  assign q_est    = REM_W'(dq_q[PROD_W-1:DRAW_W]) + REM_W'(dq_q[PROD_W-1:2*DRAW_W])
                  + REM_W'(dq_q[PROD_W-1:3*DRAW_W]);
  assign frac_rem = dq_q - PROD_W'({rem_q, {DRAW_W{1'b0}}}) + PROD_W'(rem_q);
  assign frac_fix = 2'(dq_q >= FRAC_M1) + 2'(dq_q >= FRAC_M2) + 2'(dq_q >= FRAC_M3);

  // remainder for integer range, quotient for fractional range
  assign offset       = (mode_q == MODE_FRAC) ? dq_q[DATA_W-1:0] : rem_q[DATA_W-1:0];
  assign stat_o.done  = (st_q == LN_DONE);
  assign stat_o.value = lo_q + offset;

  always_comb begin
    st_d = st_q;
    case (st_q)
      LN_IDLE: st_d = LN_IDLE;
      LN_MUL:  st_d = LN_DIV;
      LN_DIV:  if (iter_q == ITER_W'(1)) st_d = LN_DONE;
      LN_DONE: st_d = LN_DONE;
      default: st_d = LN_IDLE;
    endcase
    if (ctrl_i.start) begin
      st_d = LN_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= LN_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      draw_q <= ctrl_i.draw;
    end
    if (ctrl_i.start) begin
      mode_q <= ctrl_i.mode;
      lo_q   <= a_lt_b ? bound_a_i : bound_b_i;
      span_q <= a_lt_b ? (bound_b_i - bound_a_i) : (bound_a_i - bound_b_i);
    end else if (st_q == LN_MUL) begin
      rem_q <= '0;
      if (mode_q == MODE_FRAC) begin
        dq_q   <= prod;
        iter_q <= FRAC_ITERS;
      end else begin
        dq_q   <= {draw_q, {(PROD_W - DRAW_W){1'b0}}};
        div_q  <= {1'b0, span_q} + REM_W'(1);
        iter_q <= INT_ITERS;
      end
    end else if (st_q == LN_DIV) begin
      iter_q <= iter_q - ITER_W'(1);
      if (mode_q == MODE_FRAC) begin
        if (iter_q == FRAC_STEP_EST) begin
          rem_q <= q_est;
        end else if (iter_q == FRAC_STEP_REM) begin
          dq_q <= frac_rem;
        end else if (iter_q == FRAC_STEP_FIX) begin
          dq_q <= PROD_W'(rem_q) + PROD_W'(frac_fix);
        end
      end else begin
        rem_q <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
        dq_q  <= {dq_q[PROD_W-2:0], fits};
      end
    end
  end

endmodule

// ===== hdl/lcg_random_range_generator.sv =====
// lcg random range generator: sequencer, lanes and output merge
// one draw per cycle from the generator for each lane used (1 to 4), then the lanes run
// side by side: one remainder bit a cycle (15 bits) in integer mode, a divide by 32767
// in estimate, remainder and fix-up steps in fractional mode
// one request at a time; the next is taken in the cycle after the result is registered
// reset clears seed and generator state to zero and clears the output valid flag
`timescale 1ns / 1ps

module lcg_random_range_generator import lcgrr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     mode_i,
  input  logic [COUNT_W-1:0]       lane_count_i,
  input  logic signed [DATA_W-1:0] bound_a_0_i,
  input  logic signed [DATA_W-1:0] bound_b_0_i,
  input  logic signed [DATA_W-1:0] bound_a_1_i,
  input  logic signed [DATA_W-1:0] bound_b_1_i,
  input  logic signed [DATA_W-1:0] bound_a_2_i,
  input  logic signed [DATA_W-1:0] bound_b_2_i,
  input  logic signed [DATA_W-1:0] bound_a_3_i,
  input  logic signed [DATA_W-1:0] bound_b_3_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] value_0_o,
  output logic signed [DATA_W-1:0] value_1_o,
  output logic signed [DATA_W-1:0] value_2_o,
  output logic signed [DATA_W-1:0] value_3_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DRAW  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_MERGE = 4'b1000
  } top_state_e;

  top_state_e            st_q, st_d;
  logic                  mode_q;
  logic [COUNT_W-1:0]    lanes_q;
  logic [LANE_IDX_W-1:0] lane_idx_q;
  logic [DATA_W-1:0]     bound_a_q [LANES];
  logic [DATA_W-1:0]     bound_b_q [LANES];
  logic                  out_valid_q;
  logic [DATA_W-1:0]     value_q [LANES];

  logic                  in_acc;
  logic [COUNT_W-1:0]    lanes_in;
  logic                  last_draw;
  logic                  step;
  logic [DRAW_W-1:0]     draw;
  logic                  merge_free;
  logic                  lanes_done;
  lane_ctrl_t            lane_ctrl [LANES];
  lane_stat_t            lane_stat [LANES];
  logic [LANES-1:0]      done_vec;

  assign pready      = 1'b1;
  assign in_stall_o  = (st_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign merge_free  = !out_valid_q || !out_stall_i;
  assign step        = (st_q == ST_DRAW);
  assign last_draw   = step && ((COUNT_W'(lane_idx_q) + COUNT_W'(1)) == lanes_q);

  // lane count of zero means one lane, anything above the lane total saturates
  always_comb begin
    lanes_in = lane_count_i;
    if (lane_count_i == '0) begin
      lanes_in = COUNT_W'(1);
    end else if (lane_count_i > COUNT_W'(LANES)) begin
      lanes_in = COUNT_W'(LANES);
    end
  end

  lcgrr_lcg u_lcg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .step_i  (step),
    .draw_o  (draw)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign lane_ctrl[i].load  = step && (lane_idx_q == LANE_IDX_W'(i));
    assign lane_ctrl[i].start = last_draw;
    assign lane_ctrl[i].mode  = mode_q;
    assign lane_ctrl[i].draw  = draw;
    assign done_vec[i] = lane_stat[i].done || (COUNT_W'(i) >= lanes_q);

    lcgrr_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (lane_ctrl[i]),
      .bound_a_i (bound_a_q[i]),
      .bound_b_i (bound_b_q[i]),
      .stat_o    (lane_stat[i])
    );
  end

  assign lanes_done = &done_vec;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (in_acc) st_d = ST_DRAW;
      ST_DRAW:  if (last_draw) st_d = ST_RUN;
      ST_RUN:   if (lanes_done) st_d = ST_MERGE;
      ST_MERGE: if (merge_free) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      lane_idx_q  <= '0;
    end else begin
      st_q <= st_d;
      if (in_acc) begin
        lane_idx_q <= '0;
      end else if (step) begin
        lane_idx_q <= lane_idx_q + LANE_IDX_W'(1);
      end
      if (st_q == ST_MERGE && merge_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q       <= mode_i;
      lanes_q      <= lanes_in;
      bound_a_q[0] <= bound_a_0_i;
      bound_b_q[0] <= bound_b_0_i;
      bound_a_q[1] <= bound_a_1_i;
      bound_b_q[1] <= bound_b_1_i;
      bound_a_q[2] <= bound_a_2_i;
      bound_b_q[2] <= bound_b_2_i;
      bound_a_q[3] <= bound_a_3_i;
      bound_b_q[3] <= bound_b_3_i;
    end
    if (st_q == ST_MERGE && merge_free) begin
      for (int i = 0; i < LANES; i++) begin
        value_q[i] <= (COUNT_W'(i) < lanes_q) ? lane_stat[i].value : '0;
      end
    end
  end

  assign value_0_o = value_q[0];
  assign value_1_o = value_q[1];
  assign value_2_o = value_q[2];
  assign value_3_o = value_q[3];

  a_draw_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DRAW) |-> (COUNT_W'(lane_idx_q) < lanes_q))
    else $error("draw lane index beyond lane count");

  a_draw_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DRAW) |=> (st_q == ST_DRAW || st_q == ST_RUN))
    else $error("draw phase left to an unexpected state");

  a_merge_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MERGE && merge_free) |=> (out_valid_q && st_q == ST_IDLE))
    else $error("merge did not present a transaction");

  a_run_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN && !lanes_done) |=> (st_q == ST_RUN))
    else $error("merge started before all lanes finished");

endmodule

// ===== dv/lcg_random_range_checker.sv =====
// checker for the lcg random range generator: watches both channels and the register port
`timescale 1ns / 1ps

module lcg_random_range_checker import lcgrr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic [DATA_W-1:0]  prdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               mode_i,
  input  logic [COUNT_W-1:0] lane_count_i,
  input  logic [DATA_W-1:0]  bound_a_0_i,
  input  logic [DATA_W-1:0]  bound_b_0_i,
  input  logic [DATA_W-1:0]  bound_a_1_i,
  input  logic [DATA_W-1:0]  bound_b_1_i,
  input  logic [DATA_W-1:0]  bound_a_2_i,
  input  logic [DATA_W-1:0]  bound_b_2_i,
  input  logic [DATA_W-1:0]  bound_a_3_i,
  input  logic [DATA_W-1:0]  bound_b_3_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [DATA_W-1:0]  value_0_i,
  input  logic [DATA_W-1:0]  value_1_i,
  input  logic [DATA_W-1:0]  value_2_i,
  input  logic [DATA_W-1:0]  value_3_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  localparam logic [DATA_W-1:0] LCG_MULT  = 32'd214013;
  localparam logic [DATA_W-1:0] LCG_INC   = 32'd2531011;
  localparam logic [DRAW_W-1:0] DRAW_FULL = 15'h7FFF;

  typedef logic [LANES-1:0][DATA_W-1:0] lane_word_t;

  lane_word_t        bound_a, bound_b, rolled, seen;
  lane_word_t        rolls_due[$];
  logic [DATA_W-1:0] seed_reg;
  logic [DATA_W-1:0] lcg_state;
  int                fails;

  assign bound_a = {bound_a_3_i, bound_a_2_i, bound_a_1_i, bound_a_0_i};
  assign bound_b = {bound_b_3_i, bound_b_2_i, bound_b_1_i, bound_b_0_i};
  assign seen    = {value_3_i, value_2_i, value_1_i, value_0_i};

  function automatic logic [DRAW_W-1:0] next_draw();
    lcg_state = lcg_state * LCG_MULT + LCG_INC;
    return lcg_state[DRAW_LSB +: DRAW_W];
  endfunction

  function automatic logic [DATA_W-1:0] ranged_value(input logic frac,
                                                     input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] lo, hi;
    logic [DATA_W:0]        span;
    logic [DRAW_W-1:0]      draw;
    logic [63:0]            off;
    if (a < b) begin
      lo = a;
      hi = b;
    end else begin
      lo = b;
      hi = a;
    end
    // 33-bit span so a full-range pair cannot wrap
    span = hi - lo;
    draw = next_draw();
    if (frac)
      off = (64'(draw) * 64'(span)) / 64'(DRAW_FULL);
    else
      off = 64'(draw) % (64'(span) + 64'd1);
    return lo[DATA_W-1:0] + off[DATA_W-1:0];
  endfunction

  function automatic lane_word_t roll_lanes(input logic mode, input logic [COUNT_W-1:0] count,
                                            input lane_word_t a, input lane_word_t b);
    lane_word_t vals;
    int         used;
    used = (count == 0) ? 1 : (count > LANES) ? LANES : int'(count);
    for (int i = 0; i < LANES; i++) begin
      if (i < used)
        vals[i] = ranged_value(mode == MODE_FRAC, a[i], b[i]);
      else
        vals[i] = '0;
    end
    return vals;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_reg  = '0;
      lcg_state = '0;
      fails     = 0;
      rolls_due.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_SEED) begin
        if (pwrite) begin
          seed_reg  = pwdata;
          lcg_state = pwdata;
        end else if (prdata !== seed_reg) begin
          $error("seed: expected %h, got %h", seed_reg, prdata);
          fails++;
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (rolls_due.size() == 0) begin
          $error("result transaction with nothing outstanding");
          fails++;
        end else begin
          rolled = rolls_due.pop_front();
          for (int i = 0; i < LANES; i++) begin
            if (seen[i] !== rolled[i]) begin
              $error("value_%0d: expected %0d, got %0d", i, $signed(rolled[i]),
                     $signed(seen[i]));
              fails++;
            end
          end
        end
      end

      if (in_valid_i && !in_stall_i)
        rolls_due.push_back(roll_lanes(mode_i, lane_count_i, bound_a, bound_b));

      pending_o    <= rolls_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== dv/lcg_random_range_generator_tb.sv =====
// testbench top for the lcg random range generator: stimulus, register writes and verdict
`timescale 1ns / 1ps

module lcg_random_range_generator_tb import lcgrr_pkg::*; ();

  typedef logic [LANES-1:0][DATA_W-1:0] lane_word_t;

  localparam logic [ADDR_W-1:0] SEED_ADDR  = ADDR_W'({REG_SEED, 2'b00});
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'({~REG_SEED, 2'b00});
  localparam logic [DATA_W-1:0] INT_MIN    = 32'h8000_0000;
  localparam logic [DATA_W-1:0] INT_MAX    = 32'h7FFF_FFFF;
  localparam int                PHASES     = 6;
  localparam int                PHASE_ITEMS = 300;
  localparam int                HOLD_CYCLES = 400;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [ADDR_W-1:0]  paddr        = '0;
  logic [DATA_W-1:0]  pwdata       = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic               mode_i       = MODE_INT;
  logic [COUNT_W-1:0] lane_count_i = '0;
  logic [DATA_W-1:0]  bound_a_0_i  = '0;
  logic [DATA_W-1:0]  bound_b_0_i  = '0;
  logic [DATA_W-1:0]  bound_a_1_i  = '0;
  logic [DATA_W-1:0]  bound_b_1_i  = '0;
  logic [DATA_W-1:0]  bound_a_2_i  = '0;
  logic [DATA_W-1:0]  bound_b_2_i  = '0;
  logic [DATA_W-1:0]  bound_a_3_i  = '0;
  logic [DATA_W-1:0]  bound_b_3_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [DATA_W-1:0]  value_0_o, value_1_o, value_2_o, value_3_o;

  int                 rolls_pending;
  int                 fail_count;
  logic               calm     = 1'b0;
  logic               hold_req = 1'b0;

  lcg_random_range_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .lane_count_i (lane_count_i),
    .bound_a_0_i  (bound_a_0_i),
    .bound_b_0_i  (bound_b_0_i),
    .bound_a_1_i  (bound_a_1_i),
    .bound_b_1_i  (bound_b_1_i),
    .bound_a_2_i  (bound_a_2_i),
    .bound_b_2_i  (bound_b_2_i),
    .bound_a_3_i  (bound_a_3_i),
    .bound_b_3_i  (bound_b_3_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_0_o    (value_0_o),
    .value_1_o    (value_1_o),
    .value_2_o    (value_2_o),
    .value_3_o    (value_3_o)
  );

  lcg_random_range_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .mode_i       (mode_i),
    .lane_count_i (lane_count_i),
    .bound_a_0_i  (bound_a_0_i),
    .bound_b_0_i  (bound_b_0_i),
    .bound_a_1_i  (bound_a_1_i),
    .bound_b_1_i  (bound_b_1_i),
    .bound_a_2_i  (bound_a_2_i),
    .bound_b_2_i  (bound_b_2_i),
    .bound_a_3_i  (bound_a_3_i),
    .bound_b_3_i  (bound_b_3_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_0_i    (value_0_o),
    .value_1_i    (value_1_o),
    .value_2_i    (value_2_o),
    .value_3_i    (value_3_o),
    .pending_o    (rolls_pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls, one long hold-off while the sender keeps offering
  initial begin : receiver
    int held;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 19);
    end
  end

  function automatic lane_word_t lanes(input logic [DATA_W-1:0] l0, input logic [DATA_W-1:0] l1,
                                       input logic [DATA_W-1:0] l2, input logic [DATA_W-1:0] l3);
    return {l3, l2, l1, l0};
  endfunction

  function automatic logic [DATA_W-1:0] random_bound();
    logic [DATA_W-1:0] r;
    case ($urandom_range(0, 5))
      1: r = 32'($urandom_range(0, 200)) - 32'd100;
      2: begin
        case ($urandom_range(0, 3))
          0: r = INT_MIN;
          1: r = INT_MAX;
          2: r = '0;
          default: r = '1;
        endcase
      end
      // moderate Q16.16 values with a random fraction
      3: r = ((32'($urandom_range(0, 2000)) - 32'd1000) << 16) | 32'($urandom_range(0, 65535));
      default: r = $urandom;
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] phase_seed(input int ph);
    case (ph)
      0: return 32'hFFFF_FFFF;
      1: return 32'h0000_0000;
      2: return 32'h8000_0000;
      4: return 32'h0000_0001;
      5: return INT_MAX;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic mode, input logic [COUNT_W-1:0] count,
                              input lane_word_t a, input lane_word_t b);
    if (!calm && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 64)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    lane_count_i <= count;
    bound_a_0_i  <= a[0];
    bound_b_0_i  <= b[0];
    bound_a_1_i  <= a[1];
    bound_b_1_i  <= b[1];
    bound_a_2_i  <= a[2];
    bound_b_2_i  <= b[2];
    bound_a_3_i  <= a[3];
    bound_b_3_i  <= b[3];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random_request();
    lane_word_t         a, b;
    logic [COUNT_W-1:0] count;
    // mostly legal lane counts, now and then zero or above the lane total
    if ($urandom_range(0, 9) == 0)
      count = COUNT_W'($urandom_range(0, 7));
    else
      count = COUNT_W'($urandom_range(1, LANES));
    for (int i = 0; i < LANES; i++) begin
      a[i] = random_bound();
      b[i] = ($urandom_range(0, 7) == 0) ? a[i] : random_bound();
    end
    send_request($urandom_range(0, 1) ? MODE_FRAC : MODE_INT, count, a, b);
  endtask

  task automatic wait_all_rolled();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rolls_pending != 0) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int ph;
    int n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed transactions, generator starting from its reset state
    send_request(MODE_INT, 3'd1, lanes(0, 0, 0, 0), lanes(0, 0, 0, 0));
    send_request(MODE_INT, 3'd1, lanes(32'd10, 0, 0, 0), lanes(-32'sd10, 0, 0, 0));
    send_request(MODE_INT, 3'd1, lanes(INT_MIN, 0, 0, 0), lanes(INT_MAX, 0, 0, 0));
    send_request(MODE_INT, 3'd1, lanes(INT_MAX, 0, 0, 0), lanes(INT_MIN, 0, 0, 0));
    send_request(MODE_FRAC, 3'd1, lanes(INT_MIN, 0, 0, 0), lanes(INT_MAX, 0, 0, 0));
    send_request(MODE_FRAC, 3'd1, lanes(INT_MAX, 0, 0, 0), lanes(INT_MIN, 0, 0, 0));
    send_request(MODE_FRAC, 3'd1, lanes(32'h0005_0000, 0, 0, 0),
                 lanes(32'h0005_0000, 0, 0, 0));
    send_request(MODE_FRAC, 3'd2, lanes(32'hFFFC_8000, 32'h0001_0000, 0, 0),
                 lanes(32'h0002_4000, 0, 0, 0));
    send_request(MODE_INT, 3'd0, lanes(32'd5, 32'd7, 32'd9, 32'd11),
                 lanes(32'd100, 32'd200, 32'd300, 32'd400));
    send_request(MODE_INT, 3'd5, lanes(-32'sd1, 32'd7, INT_MIN, 32'd11),
                 lanes(32'd1, 32'd200, INT_MAX, -32'sd400));
    send_request(MODE_FRAC, 3'd7, lanes(INT_MIN, INT_MAX, 0, '1),
                 lanes(0, 0, INT_MAX, INT_MIN));
    send_request(MODE_FRAC, 3'd6, lanes(32'h0001_0000, 0, '1, 0),
                 lanes(0, 32'h0001_0000, 0, '1));
    send_request(MODE_INT, 3'd4, lanes(INT_MIN, INT_MAX, '1, 0),
                 lanes(INT_MIN, INT_MAX, 0, '1));
    send_request(MODE_FRAC, 3'd4, lanes(INT_MIN, INT_MAX, '1, 0),
                 lanes(INT_MIN, INT_MAX, 0, '1));
    send_request(MODE_INT, 3'd3, lanes(INT_MIN, 0, '1, 0), lanes(0, INT_MAX, INT_MIN, 0));
    send_request(MODE_FRAC, 3'd4, lanes(0, 32'h0001_0000, '1, INT_MIN),
                 lanes(32'd1, 0, 32'd1, '1));
    send_request(MODE_INT, 3'd2, lanes(32'd1, 32'd100, 0, 0), lanes(32'd2, -32'sd100, 0, 0));

    for (ph = 0; ph < PHASES; ph++) begin
      wait_all_rolled();
      if (ph == 0)
        reg_access(1'b1, SPARE_ADDR, $urandom);
      reg_access(1'b1, SEED_ADDR, phase_seed(ph));
      reg_access(1'b0, SEED_ADDR, '0);
      if (ph == 1)
        hold_req <= 1'b1;
      calm <= (ph == 2);
      for (n = 0; n < PHASE_ITEMS; n++) send_random_request();
    end

    wait_all_rolled();
    // catch any stray result transaction
    repeat (64) @(posedge clk_i);
    if (fail_count == 0 && rolls_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
